@@ hw/rtl/lbps_pkg.sv @@
// ----------------------------------------------------------------------------
// lbps_pkg
// Types, codes and the pattern tables of the LED blink pattern sequencer.
// ----------------------------------------------------------------------------
package lbps_pkg;

  localparam int FIELD_TIME_W = 32;
  localparam int ROM_SIZE     = 41;
  localparam int NUM_PATTERNS = 12;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [5:0] WAIT_CAP = 6'd50;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MANUAL_PATTERN  = 2'd0,
    REG_ON_POLARITY     = 2'd1,
    REG_MEDIUM_PRESS_MS = 2'd2,
    REG_LONG_PRESS_MS   = 2'd3
  } reg_index_t;

  localparam logic [3:0] PAT_AUTO       = 4'd0;
  localparam logic [3:0] PAT_OFF        = 4'd1;
  localparam logic [3:0] PAT_ON         = 4'd2;
  localparam logic [3:0] PAT_SELDOM     = 4'd3;
  localparam logic [3:0] PAT_NEG_SELDOM = 4'd5;
  localparam logic [3:0] PAT_SLOW       = 4'd8;
  localparam logic [3:0] PAT_MEDIUM     = 4'd9;
  localparam logic [3:0] PAT_FAST       = 4'd10;
  localparam logic [3:0] PAT_LAST       = 4'd11;

  localparam logic [1:0] ST_CONNECTED    = 2'd0;
  localparam logic [1:0] ST_STARTING     = 2'd1;
  localparam logic [1:0] ST_DISCONNECTED = 2'd2;
  localparam logic [1:0] ST_STOPPED      = 2'd3;

  typedef struct packed {
    logic [3:0] pattern;
    logic [5:0] pointer;
  } seq_pos_t;

  // light step: bit 0 lit, bits 6..1 duration in 10 ms; negative: rewind
  localparam logic signed [7:0] PATTERN_ROM [ROM_SIZE] = '{
    8'sd0,
    8'sd126, -8'sd1,
    8'sd127, -8'sd1,
    8'sd15, 8'sd120, 8'sd120, 8'sd120, -8'sd4,
    8'sd15, 8'sd100, -8'sd2,
    8'sd14, 8'sd121, 8'sd121, 8'sd121, -8'sd4,
    8'sd14, 8'sd101, -8'sd2,
    8'sd31, 8'sd80, 8'sd31, 8'sd80, 8'sd80, -8'sd5,
    8'sd101, 8'sd101, 8'sd100, 8'sd100, -8'sd4,
    8'sd81, 8'sd80, -8'sd2,
    8'sd21, 8'sd20, -8'sd2,
    8'sd11, 8'sd10, -8'sd2
  };

  localparam logic [5:0] PATTERN_START [NUM_PATTERNS] = '{
    6'd0, 6'd1, 6'd3, 6'd5, 6'd10, 6'd13, 6'd18, 6'd21, 6'd27, 6'd32, 6'd35, 6'd38
  };

  function automatic logic signed [7:0] rom_read(input logic [5:0] idx);
    logic signed [7:0] d;
    d = 8'sd0;
    if (idx < 6'(ROM_SIZE)) begin
      d = PATTERN_ROM[idx];
    end
    return d;
  endfunction

  function automatic logic [5:0] pattern_start(input logic [3:0] p);
    logic [5:0] s;
    s = 6'd0;
    if (p < 4'(NUM_PATTERNS)) begin
      s = PATTERN_START[p];
    end
    return s;
  endfunction

endpackage

@@ hw/rtl/lbps_if.sv @@
// ----------------------------------------------------------------------------
// lbps_poll_if / lbps_result_if
// Valid/ready channels for poll items and result items.
// ----------------------------------------------------------------------------
interface lbps_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [1:0]  station_state;
  logic        alarms_on;
  logic [31:0] press_time_ms;

  modport source (output valid, now_ms, station_state, alarms_on, press_time_ms,
                  input ready);
  modport sink   (input valid, now_ms, station_state, alarms_on, press_time_ms,
                  output ready);
endinterface

interface lbps_result_if;
  logic       valid;
  logic       ready;
  logic       led_level;
  logic [5:0] wait_ms;
  logic [3:0] active_pattern;

  modport source (output valid, led_level, wait_ms, active_pattern, input ready);
  modport sink   (input valid, led_level, wait_ms, active_pattern, output ready);
endinterface

@@ hw/rtl/led_blink_pattern_sequencer.sv @@
// ----------------------------------------------------------------------------
// led_blink_pattern_sequencer
// Path: poll register -> select/step -> result register; a held result stalls it.
// Throughput: one item per cycle unless result.ready is low with a result held.
// The state update (pattern, step pointer, deadline, level) closes in the cycle
// the poll register hands its item on to the result register.
// Reset: registers at defaults, steady-on pattern at its first step, deadline 0.
// ----------------------------------------------------------------------------
module led_blink_pattern_sequencer #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  lbps_poll_if.sink                            poll,
  lbps_result_if.source                        result,
  input  logic                                 cfg_we,
  input  logic [lbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lbps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lbps_pkg::*;

  logic [3:0]  manual_pattern;
  logic        on_polarity;
  logic [15:0] medium_press_ms;
  logic [15:0] long_press_ms;

  logic [TIME_WIDTH-1:0] deadline;
  logic [5:0]            step_pointer;
  logic [3:0]            current_pattern;
  logic                  level_reg;

  logic        s1_valid;
  logic [31:0] s1_now;
  logic [1:0]  s1_station;
  logic        s1_alarms;
  logic [31:0] s1_press;
  logic        s1_adv;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] press_t;
  logic [TIME_WIDTH-1:0] deadline_eff;
  logic [TIME_WIDTH-1:0] deadline_next;
  logic [5:0]            pointer_next;
  logic                  level_next;
  logic [5:0]            wait_next;
  logic                  restart;
  seq_pos_t              pos_cur;
  seq_pos_t              pos_sel;
  logic [3:0]            cfg_pat;

  assign s1_adv     = s1_valid && (!result.valid || result.ready);
  assign poll.ready = !s1_valid || s1_adv;

  assign now_t   = TIME_WIDTH'(s1_now);
  assign press_t = TIME_WIDTH'(s1_press);
  assign pos_cur = '{pattern: current_pattern, pointer: step_pointer};
  assign cfg_pat = cfg_data[3:0];

  lbps_select #(.TIME_WIDTH(TIME_WIDTH)) u_select (
    .now             (now_t),
    .press           (press_t),
    .station_state   (s1_station),
    .alarms_on       (s1_alarms),
    .medium_press_ms (medium_press_ms),
    .long_press_ms   (long_press_ms),
    .auto_mode       (manual_pattern == PAT_AUTO),
    .pos_in          (pos_cur),
    .pos_out         (pos_sel),
    .restart         (restart)
  );

  assign deadline_eff = restart ? '0 : deadline;

  lbps_step #(.TIME_WIDTH(TIME_WIDTH)) u_step (
    .now           (now_t),
    .deadline      (deadline_eff),
    .pointer       (pos_sel.pointer),
    .on_polarity   (on_polarity),
    .level_reg     (level_reg),
    .deadline_next (deadline_next),
    .pointer_next  (pointer_next),
    .level_next    (level_next),
    .wait_ms       (wait_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_pattern  <= PAT_AUTO;
      on_polarity     <= 1'b1;
      medium_press_ms <= 16'd1000;
      long_press_ms   <= 16'd3000;
      deadline        <= '0;
      step_pointer    <= pattern_start(PAT_ON);
      current_pattern <= PAT_ON;
      level_reg       <= 1'b0;
      s1_valid        <= 1'b0;
      result.valid    <= 1'b0;
    end else begin
      if (poll.valid && poll.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end

      if (s1_adv) begin
        deadline        <= deadline_next;
        step_pointer    <= pointer_next;
        current_pattern <= pos_sel.pattern;
        level_reg       <= level_next;
      end

      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_MANUAL_PATTERN: begin
            if (cfg_pat <= PAT_LAST) begin
              manual_pattern  <= cfg_pat;
              current_pattern <= (cfg_pat == PAT_AUTO) ? PAT_ON : cfg_pat;
              step_pointer    <= pattern_start((cfg_pat == PAT_AUTO) ? PAT_ON : cfg_pat);
              deadline        <= '0;
            end
          end
          REG_ON_POLARITY:     on_polarity     <= cfg_data[0];
          REG_MEDIUM_PRESS_MS: medium_press_ms <= cfg_data;
          REG_LONG_PRESS_MS:   long_press_ms   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_now     <= poll.now_ms;
      s1_station <= poll.station_state;
      s1_alarms  <= poll.alarms_on;
      s1_press   <= poll.press_time_ms;
    end
    if (s1_adv) begin
      result.led_level      <= level_next;
      result.wait_ms        <= wait_next;
      result.active_pattern <= pos_sel.pattern;
    end
  end

  a_wait_cap: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.wait_ms <= WAIT_CAP)
    else $error("wait time above cap");

  a_pattern_range: assert property (@(posedge clk) disable iff (rst)
    current_pattern >= PAT_OFF && current_pattern <= PAT_LAST)
    else $error("current pattern out of range");

  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result.valid)
    else $error("item handed on but no result held");

  a_restart_fires: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && restart) |=> (result.active_pattern == current_pattern))
    else $error("restarted pattern not reported");

endmodule

@@ hw/rtl/lbps_select.sv @@
// ----------------------------------------------------------------------------
// lbps_select
// Automatic pattern choice from button hold time or link state.
// ----------------------------------------------------------------------------
module lbps_select #(
  parameter int TIME_WIDTH = 32
) (
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [TIME_WIDTH-1:0] press,
  input  logic [1:0]            station_state,
  input  logic                  alarms_on,
  input  logic [15:0]           medium_press_ms,
  input  logic [15:0]           long_press_ms,
  input  logic                  auto_mode,
  input  lbps_pkg::seq_pos_t    pos_in,
  output lbps_pkg::seq_pos_t    pos_out,
  output logic                  restart
);
  import lbps_pkg::*;

  localparam int CW = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;

  logic [TIME_WIDTH-1:0] dt;
  logic [CW-1:0]         dt_w;
  logic [CW-1:0]         long_w;
  logic [CW-1:0]         long2_w;
  logic [CW-1:0]         medium_w;
  logic [3:0]            sel;

  assign dt       = now - press;
  assign dt_w     = CW'(dt);
  assign long_w   = CW'(long_press_ms);
  assign long2_w  = CW'({long_press_ms, 1'b0});
  assign medium_w = CW'(medium_press_ms);

  always_comb begin
    sel = pos_in.pattern;
    if (press != '0) begin
      priority if (dt_w > long2_w) begin
        sel = PAT_ON;
      end else if (dt_w > long_w) begin
        sel = PAT_FAST;
      end else if (dt_w > medium_w) begin
        sel = PAT_MEDIUM;
      end else begin
        sel = pos_in.pattern;
      end
    end else begin
      unique case (station_state)
        ST_CONNECTED:    sel = alarms_on ? PAT_OFF : PAT_SELDOM;
        ST_STARTING:     sel = PAT_MEDIUM;
        ST_DISCONNECTED: sel = PAT_SLOW;
        ST_STOPPED:      sel = alarms_on ? PAT_ON : PAT_NEG_SELDOM;
        default:         sel = pos_in.pattern;
      endcase
    end
  end

  assign restart = auto_mode && (sel != pos_in.pattern);

  always_comb begin
    pos_out = pos_in;
    if (restart) begin
      pos_out.pattern = sel;
      pos_out.pointer = pattern_start(sel);
    end
  end

endmodule

@@ hw/rtl/lbps_step.sv @@
// ----------------------------------------------------------------------------
// lbps_step
// Deadline check, step fetch with rewind, LED level and wait time.
// ----------------------------------------------------------------------------
module lbps_step #(
  parameter int TIME_WIDTH = 32
) (
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [TIME_WIDTH-1:0] deadline,
  input  logic [5:0]            pointer,
  input  logic                  on_polarity,
  input  logic                  level_reg,
  output logic [TIME_WIDTH-1:0] deadline_next,
  output logic [5:0]            pointer_next,
  output logic                  level_next,
  output logic [5:0]            wait_ms
);
  import lbps_pkg::*;

  logic                  fire;
  logic signed [7:0]     d1;
  logic signed [7:0]     d2;
  logic [6:0]            step;
  logic [5:0]            ptr2;
  logic [9:0]            dur;
  logic [TIME_WIDTH-1:0] remain;

  assign fire = !(now < deadline);
  assign d1   = rom_read(pointer);
  assign ptr2 = (d1 < 0) ? pointer + d1[5:0] : pointer;
  assign d2   = rom_read(ptr2);
  assign step = (d2 < 0) ? 7'd0 : d2[6:0];
  assign dur  = {1'b0, step[6:1], 3'b000} + {3'b000, step[6:1], 1'b0};
  assign remain = deadline - now;

  always_comb begin
    if (fire) begin
      deadline_next = now + TIME_WIDTH'(dur);
      pointer_next  = ptr2 + 6'd1;
      level_next    = (on_polarity == step[0]);
      wait_ms       = (dur > 10'(WAIT_CAP)) ? WAIT_CAP : dur[5:0];
    end else begin
      deadline_next = deadline;
      pointer_next  = pointer;
      level_next    = level_reg;
      wait_ms       = (remain > TIME_WIDTH'(WAIT_CAP)) ? WAIT_CAP : remain[5:0];
    end
  end

endmodule
